[rtl/bsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants of the background score learner.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int FRAME_PIXELS = 307200;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);

    localparam int PIX_IDX_W = 19;
    localparam int GRAY_W    = 8;
    localparam int SCORE_W   = 9;
    localparam int SENS_W    = 8;
    localparam int DEC_W     = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_SENSITIVITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_DECREMENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORGET_SCORE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_CEILING    = 3'd4;

    localparam logic [SENS_W-1:0]  RST_DIFF_SENSITIVITY = 8'd10;
    localparam logic [DEC_W-1:0]   RST_SCORE_DECREMENT  = 7'd4;
    localparam logic [SCORE_W-1:0] RST_FORGET_SCORE     = 9'd150;
    localparam logic [SCORE_W-1:0] RST_LEARN_LEVEL      = 9'd120;
    localparam logic [SCORE_W-1:0] RST_SCORE_CEILING    = 9'd300;

    typedef struct packed {
        logic [SENS_W-1:0]  diff_sensitivity;
        logic [DEC_W-1:0]   score_decrement;
        logic [SCORE_W-1:0] forget_score;
        logic [SCORE_W-1:0] learn_level;
        logic [SCORE_W-1:0] score_ceiling;
    } t_cfg;

    // one memory word: score and background of one pixel
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [GRAY_W-1:0]  bg;
    } t_entry;

endpackage

[rtl/bsl_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_pix_if
// Pixel request channel: index, current and previous gray value.
// ----------------------------------------------------------------------------
interface bsl_pix_if;
    logic        valid;
    logic        ready;
    logic [18:0] pixel_index;
    logic [7:0]  cur_pixel;
    logic [7:0]  prev_pixel;

    modport source (output valid, output pixel_index, output cur_pixel,
                    output prev_pixel, input ready);
    modport sink   (input valid, input pixel_index, input cur_pixel,
                    input prev_pixel, output ready);
endinterface

[rtl/bsl_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_res_if
// Result channel: updated background, score and background write flag.
// ----------------------------------------------------------------------------
interface bsl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] bg_pixel;
    logic [8:0] pixel_score;
    logic       bg_written;

    modport source (output valid, output bg_pixel, output pixel_score,
                    output bg_written, input ready);
    modport sink   (input valid, input bg_pixel, input pixel_score,
                    input bg_written, output ready);
endinterface

[rtl/bsl_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsl_update
// Score and background update of one pixel entry.
// ----------------------------------------------------------------------------
module bsl_update
    import bsl_pkg::*;
(
    input  t_cfg              i_cfg,
    input  t_entry            i_old,
    input  logic [GRAY_W-1:0] i_cur,
    input  logic [GRAY_W-1:0] i_prev,
    output t_entry            o_new,
    output logic              o_wrote
);

    logic [GRAY_W-1:0]  change;
    logic               moved;
    logic [SCORE_W:0]   inc;
    logic               learn_hit;
    logic               over_max;
    logic [SCORE_W-1:0] dec_score;

    always_comb begin
        change    = (i_cur > i_prev) ? (i_cur - i_prev) : (i_prev - i_cur);
        moved     = change > i_cfg.diff_sensitivity;
        inc       = {1'b0, i_old.score} + {{SCORE_W{1'b0}}, 1'b1};
        learn_hit = inc == {1'b0, i_cfg.learn_level};
        over_max  = inc > {1'b0, i_cfg.score_ceiling};

        if (i_old.score == i_cfg.score_ceiling) begin
            dec_score = i_cfg.forget_score;
        end else if (i_old.score > {2'b00, i_cfg.score_decrement}) begin
            dec_score = i_old.score - {2'b00, i_cfg.score_decrement};
        end else begin
            dec_score = '0;
        end

        if (moved) begin
            o_new.score = dec_score;
            o_new.bg    = i_old.bg;
            o_wrote     = 1'b0;
        end else begin
            // clamp at the maximum, which also refreshes the background
            o_new.score = over_max ? i_cfg.score_ceiling : inc[SCORE_W-1:0];
            o_wrote     = learn_hit | over_max;
            o_new.bg    = o_wrote ? i_cur : i_old.bg;
        end
    end

endmodule

[rtl/background_score_learner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_score_learner
// Per-pixel stability score with selective background refresh.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake        | Payload
// i_pix    | in  | valid / ready    | pixel_index, cur_pixel, prev_pixel
// o_res    | out | valid / ready    | bg_pixel, pixel_score, bg_written
// i_cfg_*  | in  | write enable     | register index, write data
//
// One pixel per clock sustained while o_res is not stalled. The score/background memory has a
// registered read in the update stage; the result is then registered in the output register.
// Back-to-back requests to the same pixel are served by a one-entry forward path.
// After reset a clearing pass zeroes all 307200 entries of the memory, one entry
// per cycle; requests are held off until it ends.
// A stalled result holds the update stage; a request is still taken meanwhile only while that stage is empty.
// ----------------------------------------------------------------------------
module background_score_learner
    import bsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsl_pix_if.sink               i_pix,
    bsl_res_if.source             o_res
);

    t_entry r_mem [FRAME_PIXELS];

    t_cfg r_cfg;

    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_s1_valid;
    logic              r_s1_in_range;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [GRAY_W-1:0] r_s1_cur;
    logic [GRAY_W-1:0] r_s1_prev;
    t_entry            r_rd_data;
    logic              r_fwd_hit;
    t_entry            r_fwd_data;

    logic               r_out_valid;
    logic [GRAY_W-1:0]  r_out_bg;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_wrote;

    logic              s1_adv;
    logic              in_acc;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    t_entry            old_entry;
    t_entry            new_entry;
    logic              new_wrote;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_sensitivity <= RST_DIFF_SENSITIVITY;
            r_cfg.score_decrement  <= RST_SCORE_DECREMENT;
            r_cfg.forget_score     <= RST_FORGET_SCORE;
            r_cfg.learn_level      <= RST_LEARN_LEVEL;
            r_cfg.score_ceiling    <= RST_SCORE_CEILING;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIFF_SENSITIVITY: r_cfg.diff_sensitivity <= i_cfg_data[SENS_W-1:0];
                CFG_SCORE_DECREMENT:  r_cfg.score_decrement  <= i_cfg_data[DEC_W-1:0];
                CFG_FORGET_SCORE:     r_cfg.forget_score     <= i_cfg_data[SCORE_W-1:0];
                CFG_LEARN_LEVEL:      r_cfg.learn_level      <= i_cfg_data[SCORE_W-1:0];
                CFG_SCORE_CEILING:    r_cfg.score_ceiling    <= i_cfg_data[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_clr_active && (!r_s1_valid || s1_adv);
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign in_range    = i_pix.pixel_index < PIX_IDX_W'(FRAME_PIXELS);
    // keep the read address inside the memory for out-of-frame requests
    assign in_addr     = in_range ? i_pix.pixel_index[ADDR_W-1:0] : '0;

    assign old_entry = r_fwd_hit ? r_fwd_data : r_rd_data;

    bsl_update u_update (
        .i_cfg   (r_cfg),
        .i_old   (old_entry),
        .i_cur   (r_s1_cur),
        .i_prev  (r_s1_prev),
        .o_new   (new_entry),
        .o_wrote (new_wrote)
    );

    always_comb begin
        if (r_clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_adv && r_s1_in_range;
            mem_waddr = r_s1_addr;
            mem_wdata = new_entry;
        end
    end

    // memory: registered read, write-back of the updated entry or clearing write
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= r_mem[in_addr];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == ADDR_W'(FRAME_PIXELS - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            // the entry being written this edge is read stale: forward it
            r_fwd_hit  <= s1_adv && r_s1_in_range && in_range && (r_s1_addr == in_addr);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_s1_cur      <= i_pix.cur_pixel;
            r_s1_prev     <= i_pix.prev_pixel;
            r_fwd_data    <= new_entry;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_bg    <= r_s1_in_range ? new_entry.bg : '0;
            r_out_score <= r_s1_in_range ? new_entry.score : '0;
            r_out_wrote <= r_s1_in_range && new_wrote;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.bg_pixel    = r_out_bg;
    assign o_res.pixel_score = r_out_score;
    assign o_res.bg_written  = r_out_wrote;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_pix.ready)
        else $error("request taken during clearing pass");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> (r_s1_valid && r_s1_in_range))
        else $error("forward hit without an in-frame entry in the update stage");

    a_no_write_out_of_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_clr_active && r_s1_valid && !r_s1_in_range) |-> !mem_we)
        else $error("memory written by an out-of-frame request");

    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_addr)))
        else $error("update stage lost its entry during a stall");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the per-pixel score and background update of background_score_learner.
// Pixel requests and results pass through valid/ready channels that both
// stall at random. A scoreboard in this file follows the score and the
// background of every touched pixel. Each result is compared in order with its
// prediction. The run steps through several register settings, the range
// limits among them.
// ----------------------------------------------------------------------------
module testbench;
    import bsl_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    // the idle limit covers the memory clearing pass after reset over FRAME_PIXELS entries
    localparam int IDLE_LIMIT    = 4 * FRAME_PIXELS;

    typedef struct packed {
        logic [GRAY_W-1:0]  bg_pixel;
        logic [SCORE_W-1:0] pixel_score;
        logic               bg_written;
    } pixel_update_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bsl_pix_if pix ();
    bsl_res_if res ();

    background_score_learner i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    t_cfg               learner_cfg;
    logic [SCORE_W-1:0] score_mem [int];
    logic [GRAY_W-1:0]  bg_mem [int];
    pixel_update_t      pending_updates [$];
    int                 mismatch_count;
    int                 idle_cycles;
    bit                 no_idle;

    always #(CLK_HALF) i_clk = ~i_clk;

    // scoreboard: score and background update of one pixel
    function automatic pixel_update_t learn_pixel(input logic [PIX_IDX_W-1:0] idx,
                                                  input logic [GRAY_W-1:0] cur,
                                                  input logic [GRAY_W-1:0] prev);
        pixel_update_t     upd;
        int                change;
        int                score;
        logic [GRAY_W-1:0] bg;
        upd = '0;
        if (idx >= FRAME_PIXELS) begin
            return upd;
        end
        change = (cur > prev) ? int'(cur) - int'(prev) : int'(prev) - int'(cur);
        score  = score_mem.exists(int'(idx)) ? int'(score_mem[int'(idx)]) : 0;
        bg     = bg_mem.exists(int'(idx)) ? bg_mem[int'(idx)] : '0;
        if (change > int'(learner_cfg.diff_sensitivity)) begin
            if (score == int'(learner_cfg.score_ceiling)) begin
                score = int'(learner_cfg.forget_score);
            end else if (score > int'(learner_cfg.score_decrement)) begin
                score -= int'(learner_cfg.score_decrement);
            end else begin
                score = 0;
            end
        end else begin
            score += 1;
            if (score == int'(learner_cfg.learn_level)) begin
                bg             = cur;
                upd.bg_written = 1'b1;
            end
            if (score > int'(learner_cfg.score_ceiling)) begin
                score          = int'(learner_cfg.score_ceiling);
                bg             = cur;
                upd.bg_written = 1'b1;
            end
        end
        score_mem[int'(idx)] = score[SCORE_W-1:0];
        bg_mem[int'(idx)]    = bg;
        upd.bg_pixel         = bg;
        upd.pixel_score      = score[SCORE_W-1:0];
        return upd;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_pixel(input logic [PIX_IDX_W-1:0] idx,
                              input logic [GRAY_W-1:0] cur,
                              input logic [GRAY_W-1:0] prev);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_index <= idx;
        pix.cur_pixel   <= cur;
        pix.prev_pixel  <= prev;
        do @(posedge i_clk); while (!pix.ready);
        pending_updates = {pending_updates, learn_pixel(idx, cur, prev)};
    endtask

    task automatic wait_for_drain();
        while (pending_updates.size() != 0) @(posedge i_clk);
    endtask

    // drop valid first so the held request is not taken twice
    task automatic hold_until_drained();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        wait_for_drain();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DIFF_SENSITIVITY: learner_cfg.diff_sensitivity = data[SENS_W-1:0];
            CFG_SCORE_DECREMENT:  learner_cfg.score_decrement  = data[DEC_W-1:0];
            CFG_FORGET_SCORE:     learner_cfg.forget_score     = data[SCORE_W-1:0];
            CFG_LEARN_LEVEL:      learner_cfg.learn_level      = data[SCORE_W-1:0];
            CFG_SCORE_CEILING:    learner_cfg.score_ceiling    = data[SCORE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input int sens, input int dec, input int forget,
                                  input int learn, input int max_s);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_DIFF_SENSITIVITY, CFG_DATA_W'(sens));
        write_register(CFG_SCORE_DECREMENT, CFG_DATA_W'(dec));
        write_register(CFG_FORGET_SCORE, CFG_DATA_W'(forget));
        write_register(CFG_LEARN_LEVEL, CFG_DATA_W'(learn));
        write_register(CFG_SCORE_CEILING, CFG_DATA_W'(max_s));
        i_cfg_we <= 1'b0;
    endtask

    task automatic make_gray_pair(input int diff, output logic [GRAY_W-1:0] a,
                                  output logic [GRAY_W-1:0] b);
        int low;
        low = $urandom_range(0, 255 - diff);
        if ($urandom_range(0, 1) == 1) begin
            a = GRAY_W'(low);
            b = GRAY_W'(low + diff);
        end else begin
            a = GRAY_W'(low + diff);
            b = GRAY_W'(low);
        end
    endtask

    // mostly a small set of pixels so scores climb to the thresholds
    task automatic run_random_pixels(input int count, input int pool_size,
                                     input int move_pct);
        int                   pool [8];
        int                   pick;
        int                   diff;
        int                   sens;
        logic [PIX_IDX_W-1:0] idx;
        logic [GRAY_W-1:0]    cur;
        logic [GRAY_W-1:0]    prev;
        for (int k = 0; k < 8; k++) begin
            pool[k] = int'($urandom_range(0, FRAME_PIXELS - 1));
        end
        pool[0] = ($urandom_range(0, 1) == 1) ? FRAME_PIXELS - 1 : 0;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (i == count / 2 || $urandom_range(0, 59) == 0) begin
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                idx = PIX_IDX_W'($urandom());
            end else if (pick < 15) begin
                idx = PIX_IDX_W'($urandom_range(0, FRAME_PIXELS - 1));
            end else begin
                idx = PIX_IDX_W'(pool[$urandom_range(0, pool_size - 1)]);
            end
            sens = int'(learner_cfg.diff_sensitivity);
            if ($urandom_range(0, 99) >= move_pct) begin
                diff = $urandom_range(0, sens);
            end else if (sens < 255) begin
                diff = $urandom_range(sens + 1, 255);
            end else begin
                diff = $urandom_range(0, 255);
            end
            make_gray_pair(diff, cur, prev);
            send_pixel(idx, cur, prev);
        end
        pix.valid <= 1'b0;
        no_idle = 1'b0;
    endtask

    task automatic test_reset_values();
        // boundary values under the reset settings
        send_pixel(PIX_IDX_W'(0), 8'd0, 8'd0);
        send_pixel(PIX_IDX_W'(FRAME_PIXELS - 1), 8'd255, 8'd255);
        send_pixel(PIX_IDX_W'(FRAME_PIXELS - 1), 8'd255, 8'd245);
        send_pixel(PIX_IDX_W'(FRAME_PIXELS - 1), 8'd245, 8'd255);
        send_pixel(PIX_IDX_W'(FRAME_PIXELS - 1), 8'd0, 8'd255);
        send_pixel(PIX_IDX_W'(FRAME_PIXELS), 8'd12, 8'd200);
        send_pixel(19'h7FFFF, 8'd255, 8'd0);
        send_pixel(19'h40000, 8'd170, 8'd85);
        send_pixel(19'h2AAAA, 8'd85, 8'd85);
        send_pixel(PIX_IDX_W'(1), 8'd11, 8'd0);
        send_pixel(PIX_IDX_W'(1), 8'd0, 8'd11);
        // same pixel back to back exercises the forward path
        no_idle = 1'b1;
        repeat (6) send_pixel(PIX_IDX_W'(7), 8'd100, 8'd95);
        send_pixel(PIX_IDX_W'(7), 8'd200, 8'd0);
        send_pixel(PIX_IDX_W'(7), 8'd200, 8'd200);
        no_idle = 1'b0;
        pix.valid <= 1'b0;
        run_random_pixels(80, 3, 25);
    endtask

    task automatic test_low_limits();
        write_settings(0, 1, 119, 0, 50);
        run_random_pixels(230, 3, 25);
    endtask

    // learn threshold one above the maximum: both refresh conditions at once
    task automatic test_both_refresh_conditions();
        write_settings(20, 100, 300, 51, 50);
        run_random_pixels(230, 4, 20);
    endtask

    task automatic test_high_limits();
        write_settings(254, 100, 300, 300, 500);
        run_random_pixels(380, 1, 0);
    endtask

    task automatic test_small_thresholds();
        write_settings(5, 7, 130, 20, 60);
        run_random_pixels(230, 4, 30);
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            write_settings($urandom_range(0, 254), $urandom_range(1, 100),
                           $urandom_range(119, 300), $urandom_range(0, 300),
                           $urandom_range(50, 500));
            run_random_pixels(100, 2, 25);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        pixel_update_t want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_updates.size() == 0) begin
                note_mismatch($sformatf("result with no pending request: bg %0d score %0d",
                                        res.bg_pixel, res.pixel_score));
            end else begin
                want = pending_updates.pop_front();
                if (res.bg_pixel !== want.bg_pixel) begin
                    note_mismatch($sformatf("bg_pixel expected %0d, got %0d",
                                            want.bg_pixel, res.bg_pixel));
                end
                if (res.pixel_score !== want.pixel_score) begin
                    note_mismatch($sformatf("pixel_score expected %0d, got %0d",
                                            want.pixel_score, res.pixel_score));
                end
                if (res.bg_written !== want.bg_written) begin
                    note_mismatch($sformatf("bg_written expected %0b, got %0b",
                                            want.bg_written, res.bg_written));
                end
            end
        end
    end

    // result side: random stall before each result
    initial begin
        int gap;
        res.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!res.valid);
        end
    end

    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_DIFF_SENSITIVITY;
        i_cfg_data      <= '0;
        pix.valid       <= 1'b0;
        pix.pixel_index <= '0;
        pix.cur_pixel   <= '0;
        pix.prev_pixel  <= '0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        no_idle         = 1'b0;
        learner_cfg     = '{diff_sensitivity: RST_DIFF_SENSITIVITY,
                            score_decrement:  RST_SCORE_DECREMENT,
                            forget_score:     RST_FORGET_SCORE,
                            learn_level:      RST_LEARN_LEVEL,
                            score_ceiling:    RST_SCORE_CEILING};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_low_limits();
        test_both_refresh_conditions();
        test_high_limits();
        test_small_thresholds();
        test_random_settings();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
